@@ hdl/lpi_pkg.sv @@
// shared types and widths for the line-plane intersection pipeline
// no dependencies
package lpi_pkg;

    localparam int CW   = 32;           // coordinate width
    localparam int FB   = 16;           // fraction bits
    localparam int TW   = 17;           // threshold width
    localparam int DW   = CW + 1;       // coordinate difference
    localparam int PW   = 2 * CW + 1;   // one dot product term
    localparam int SW   = PW + 2;       // sum of three terms
    localparam int MW   = SW - 1;       // magnitude of a sum
    localparam int HW   = (MW + 1) / 2; // half of a magnitude
    localparam int PPW  = DW + HW;      // partial product
    localparam int NW   = PPW + HW + 2; // dividend
    localparam int DENW = MW + 1;       // divisor
    localparam int QB   = CW + 2;       // quotient bits kept
    localparam int HWID = CW + 4;       // sum before saturation

    typedef struct packed {
        logic signed [CW-1:0] plane_point_x;
        logic signed [CW-1:0] plane_point_y;
        logic signed [CW-1:0] plane_point_z;
        logic signed [CW-1:0] normal_x;
        logic signed [CW-1:0] normal_y;
        logic signed [CW-1:0] normal_z;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } lpi_item_t;

    typedef struct packed {
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
        logic                 is_parallel;
        logic                 overflowed;
    } lpi_result_t;

    typedef struct packed {
        logic                 valid;
        logic                 par;
        logic                 neg;
        logic [MW-1:0]        dp_mag;
        logic [MW-1:0]        num_mag;
        logic [2:0][DW-1:0]   v;
        logic [2:0][CW-1:0]   s;
    } lpi_dot_t;

    typedef struct packed {
        logic                 valid;
        logic                 par;
        logic [2:0]           neg;
        logic [2:0]           big;
        logic [2:0][CW-1:0]   s;
        logic [DENW-1:0]      den;
        logic [2:0][DENW-1:0] rem;
        logic [2:0][QB-1:0]   low;
        logic [2:0][QB-1:0]   quo;
    } lpi_div_t;

endpackage

@@ hdl/lpi_dot.sv @@
// direction, dot products and parallel test, four register stages
// depends on lpi_pkg
module lpi_dot
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  lpi_pkg::lpi_item_t            item,
    input  logic [lpi_pkg::TW-1:0]        thr,
    output lpi_pkg::lpi_dot_t             dot
);

    logic                            s1_valid_reg;
    logic signed [lpi_pkg::DW-1:0]   s1_v_reg [3];
    logic signed [lpi_pkg::DW-1:0]   s1_d_reg [3];
    logic signed [lpi_pkg::CW-1:0]   s1_n_reg [3];
    logic signed [lpi_pkg::CW-1:0]   s1_s_reg [3];

    logic                            s2_valid_reg;
    logic signed [lpi_pkg::PW-1:0]   s2_pv_reg [3];
    logic signed [lpi_pkg::PW-1:0]   s2_pd_reg [3];
    logic [2:0][lpi_pkg::DW-1:0]     s2_v_reg;
    logic [2:0][lpi_pkg::CW-1:0]     s2_s_reg;

    logic                            s3_valid_reg;
    logic signed [lpi_pkg::SW-1:0]   s3_dp_reg;
    logic signed [lpi_pkg::SW-1:0]   s3_sd_reg;
    logic [2:0][lpi_pkg::DW-1:0]     s3_v_reg;
    logic [2:0][lpi_pkg::CW-1:0]     s3_s_reg;

    logic                            s4_valid_reg;
    lpi_pkg::lpi_dot_t               s4_reg;
    lpi_pkg::lpi_dot_t               s4_next;

    logic [lpi_pkg::SW-1:0]          dp_abs;
    logic [lpi_pkg::SW-1:0]          sd_abs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: differences
    always_ff @(posedge clk)
    begin
        s1_v_reg[0] <= lpi_pkg::DW'(item.end_x) - lpi_pkg::DW'(item.start_x);
        s1_v_reg[1] <= lpi_pkg::DW'(item.end_y) - lpi_pkg::DW'(item.start_y);
        s1_v_reg[2] <= lpi_pkg::DW'(item.end_z) - lpi_pkg::DW'(item.start_z);
        s1_d_reg[0] <= lpi_pkg::DW'(item.start_x) - lpi_pkg::DW'(item.plane_point_x);
        s1_d_reg[1] <= lpi_pkg::DW'(item.start_y) - lpi_pkg::DW'(item.plane_point_y);
        s1_d_reg[2] <= lpi_pkg::DW'(item.start_z) - lpi_pkg::DW'(item.plane_point_z);
        s1_n_reg[0] <= item.normal_x;
        s1_n_reg[1] <= item.normal_y;
        s1_n_reg[2] <= item.normal_z;
        s1_s_reg[0] <= item.start_x;
        s1_s_reg[1] <= item.start_y;
        s1_s_reg[2] <= item.start_z;
    end

    // stage 2: products, stage 3: sums
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_pv_reg[i] <= lpi_pkg::PW'(s1_n_reg[i]) * lpi_pkg::PW'(s1_v_reg[i]);
            s2_pd_reg[i] <= lpi_pkg::PW'(s1_n_reg[i]) * lpi_pkg::PW'(s1_d_reg[i]);
            s2_v_reg[i]  <= s1_v_reg[i];
            s2_s_reg[i]  <= s1_s_reg[i];
        end
        s3_dp_reg <= lpi_pkg::SW'(s2_pv_reg[0]) + lpi_pkg::SW'(s2_pv_reg[1])
                   + lpi_pkg::SW'(s2_pv_reg[2]);
        s3_sd_reg <= lpi_pkg::SW'(s2_pd_reg[0]) + lpi_pkg::SW'(s2_pd_reg[1])
                   + lpi_pkg::SW'(s2_pd_reg[2]);
        s3_v_reg  <= s2_v_reg;
        s3_s_reg  <= s2_s_reg;
    end

    // stage 4: magnitudes and parallel test
    always_comb
    begin
        dp_abs = (s3_dp_reg < 0) ? lpi_pkg::SW'(-s3_dp_reg) : lpi_pkg::SW'(s3_dp_reg);
        sd_abs = (s3_sd_reg < 0) ? lpi_pkg::SW'(-s3_sd_reg) : lpi_pkg::SW'(s3_sd_reg);
        s4_next         = '0;
        s4_next.dp_mag  = dp_abs[lpi_pkg::MW-1:0];
        s4_next.num_mag = sd_abs[lpi_pkg::MW-1:0];
        s4_next.par     = (dp_abs == '0)
                       || (dp_abs[lpi_pkg::MW-1:0]
                           < lpi_pkg::MW'({thr, {lpi_pkg::FB{1'b0}}}));
        // numerator is the negated sum
        s4_next.neg     = (s3_sd_reg > 0) ^ (s3_dp_reg < 0);
        s4_next.v       = s3_v_reg;
        s4_next.s       = s3_s_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_reg <= s4_next;
    end

    always_comb
    begin
        dot       = s4_reg;
        dot.valid = s4_valid_reg;
    end

endmodule

@@ hdl/lpi_div_step.sv @@
// one restoring division step for three lanes, registered
// depends on lpi_pkg
module lpi_div_step
(
    input  logic              clk,
    input  logic              rst_n,
    input  lpi_pkg::lpi_div_t d_in,
    output lpi_pkg::lpi_div_t d_out
);

    logic                          valid_reg;
    lpi_pkg::lpi_div_t             data_reg;
    lpi_pkg::lpi_div_t             data_next;
    logic [lpi_pkg::DENW:0]        trial;
    logic                          qbit;

    always_comb
    begin
        data_next = d_in;
        trial     = '0;
        qbit      = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            trial = {d_in.rem[i], d_in.low[i][lpi_pkg::QB-1]};
            qbit  = (trial >= {1'b0, d_in.den});
            if (qbit)
            begin
                trial = trial - {1'b0, d_in.den};
            end
            data_next.rem[i] = trial[lpi_pkg::DENW-1:0];
            data_next.low[i] = {d_in.low[i][lpi_pkg::QB-2:0], 1'b0};
            data_next.quo[i] = {d_in.quo[i][lpi_pkg::QB-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

@@ hdl/line_plane_intersection.sv @@
// top level: dot stages, scaling, division chain and saturation
// depends on lpi_pkg, lpi_dot, lpi_div_step
//
//  port group        dir  meaning
//  start/item        in   one segment and plane word, taken when start is high
//  done/result       out  one hit word, valid for the single cycle done is high
//  thr_we/thr_data   in   parallel threshold write
//
// one word enters per cycle; results leave in the order their words came in
// the division chain has 34 quotient bit stages, one bit per stage
// busy stays low: the pipeline never stalls and the receiver cannot stall
// reset clears the valid bits and sets the threshold to 7
module line_plane_intersection
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lpi_pkg::lpi_item_t         item,
    input  logic                       thr_we,
    input  logic [lpi_pkg::TW-1:0]     thr_data,
    output logic                       done,
    output lpi_pkg::lpi_result_t       result
);

    logic [lpi_pkg::TW-1:0]            thr_reg;
    lpi_pkg::lpi_dot_t                 dot;

    logic                              s5_valid_reg;
    logic                              s5_par_reg;
    logic [2:0]                        s5_neg_reg;
    logic [2:0][lpi_pkg::CW-1:0]       s5_s_reg;
    logic [lpi_pkg::MW-1:0]            s5_dp_reg;
    logic [2:0][lpi_pkg::PPW-1:0]      s5_pl_reg;
    logic [2:0][lpi_pkg::PPW-1:0]      s5_ph_reg;

    logic                              s6_valid_reg;
    logic                              s6_par_reg;
    logic [2:0]                        s6_neg_reg;
    logic [2:0][lpi_pkg::CW-1:0]       s6_s_reg;
    logic [lpi_pkg::DENW-1:0]          s6_den_reg;
    logic [2:0][lpi_pkg::NW-1:0]       s6_dvd_reg;

    logic                              s7_valid_reg;
    lpi_pkg::lpi_div_t                 s7_reg;
    lpi_pkg::lpi_div_t                 s7_next;

    lpi_pkg::lpi_div_t                 chain [lpi_pkg::QB+1];

    logic                              done_reg;
    lpi_pkg::lpi_result_t              result_reg;
    lpi_pkg::lpi_result_t              result_next;

    logic [lpi_pkg::DW-1:0]            v_abs [3];
    logic signed [lpi_pkg::HWID-1:0]   h;
    logic signed [lpi_pkg::CW-1:0]     hit [3];
    logic                              ovf;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= lpi_pkg::TW'(7);
        end
        else if (thr_we)
        begin
            thr_reg <= thr_data;
        end
    end

    lpi_dot u_dot
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .thr   (thr_reg),
        .dot   (dot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= dot.valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            done_reg     <= chain[lpi_pkg::QB].valid;
        end
    end

    // stage 5: partial products of |v| and |num|
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_abs[i] = dot.v[i][lpi_pkg::DW-1] ? (~dot.v[i] + 1'b1) : dot.v[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_pl_reg[i]  <= lpi_pkg::PPW'(v_abs[i])
                           * lpi_pkg::PPW'(dot.num_mag[lpi_pkg::HW-1:0]);
            s5_ph_reg[i]  <= lpi_pkg::PPW'(v_abs[i])
                           * lpi_pkg::PPW'(dot.num_mag[lpi_pkg::MW-1:lpi_pkg::HW]);
            s5_neg_reg[i] <= dot.neg ^ dot.v[i][lpi_pkg::DW-1];
        end
        s5_par_reg <= dot.par;
        s5_s_reg   <= dot.s;
        s5_dp_reg  <= dot.dp_mag;
    end

    // stage 6: dividend 2a + |dp| for rounding, divisor 2|dp|
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_dvd_reg[i] <= ((lpi_pkg::NW'(s5_ph_reg[i]) << lpi_pkg::HW)
                            + lpi_pkg::NW'(s5_pl_reg[i])) * lpi_pkg::NW'(2)
                           + lpi_pkg::NW'(s5_dp_reg);
        end
        s6_den_reg <= {s5_dp_reg, 1'b0};
        s6_par_reg <= s5_par_reg;
        s6_neg_reg <= s5_neg_reg;
        s6_s_reg   <= s5_s_reg;
    end

    // stage 7: quotient range check and first remainder
    always_comb
    begin
        s7_next       = '0;
        s7_next.par   = s6_par_reg;
        s7_next.neg   = s6_neg_reg;
        s7_next.s     = s6_s_reg;
        s7_next.den   = s6_den_reg;
        for (int i = 0; i < 3; i++)
        begin
            s7_next.big[i] = (s6_dvd_reg[i] >= {s6_den_reg, {lpi_pkg::QB{1'b0}}});
            s7_next.rem[i] = s6_dvd_reg[i][lpi_pkg::NW-1:lpi_pkg::QB];
            s7_next.low[i] = s6_dvd_reg[i][lpi_pkg::QB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s7_reg <= s7_next;
    end

    always_comb
    begin
        chain[0]       = s7_reg;
        chain[0].valid = s7_valid_reg;
    end

    for (genvar g = 0; g < lpi_pkg::QB; g++)
    begin : g_div
        lpi_div_step u_step
        (
            .clk   (clk),
            .rst_n (rst_n),
            .d_in  (chain[g]),
            .d_out (chain[g+1])
        );
    end

    // final stage: add offset to start and saturate, or pass start through when parallel
    always_comb
    begin
        ovf = 1'b0;
        h   = '0;
        for (int i = 0; i < 3; i++)
        begin
            h = lpi_pkg::HWID'($signed(chain[lpi_pkg::QB].s[i]));
            if (chain[lpi_pkg::QB].neg[i])
            begin
                h = h - $signed(lpi_pkg::HWID'(chain[lpi_pkg::QB].quo[i]));
            end
            else
            begin
                h = h + $signed(lpi_pkg::HWID'(chain[lpi_pkg::QB].quo[i]));
            end
            if (chain[lpi_pkg::QB].big[i])
            begin
                ovf    = 1'b1;
                hit[i] = chain[lpi_pkg::QB].neg[i] ? {1'b1, {(lpi_pkg::CW-1){1'b0}}}
                                                   : {1'b0, {(lpi_pkg::CW-1){1'b1}}};
            end
            else if (h > lpi_pkg::HWID'($signed({1'b0, {(lpi_pkg::CW-1){1'b1}}})))
            begin
                ovf    = 1'b1;
                hit[i] = {1'b0, {(lpi_pkg::CW-1){1'b1}}};
            end
            else if (h < lpi_pkg::HWID'($signed({1'b1, {(lpi_pkg::CW-1){1'b0}}})))
            begin
                ovf    = 1'b1;
                hit[i] = {1'b1, {(lpi_pkg::CW-1){1'b0}}};
            end
            else
            begin
                hit[i] = h[lpi_pkg::CW-1:0];
            end
        end
        if (chain[lpi_pkg::QB].par)
        begin
            result_next.hit_x       = chain[lpi_pkg::QB].s[0];
            result_next.hit_y       = chain[lpi_pkg::QB].s[1];
            result_next.hit_z       = chain[lpi_pkg::QB].s[2];
            result_next.is_parallel = 1'b1;
            result_next.overflowed  = 1'b0;
        end
        else
        begin
            result_next.hit_x       = hit[0];
            result_next.hit_y       = hit[1];
            result_next.hit_z       = hit[2];
            result_next.is_parallel = 1'b0;
            result_next.overflowed  = ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
